@@ design/swfd_pkg.sv @@
// Shared types, constants and the CRC-8 step for the sensor word frame decoder.
package swfd_pkg;

    localparam logic [7:0]  CRC_POLY   = 8'h31;
    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    localparam logic [10:0] READY_MASK = 11'h7FF;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_MEAS   = 1'b1;

    localparam logic [3:0] LAST_POS_STATUS = 4'd2;
    localparam logic [3:0] LAST_POS_MEAS   = 4'd8;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;

    localparam int TDATA_IN_W  = 8;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 48;

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_LOW,
        PH_CRC
    } phase_t;

    // Frame tracker output for the current beat
    typedef struct packed {
        logic        emit;
        logic        ok;
        logic        kind;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
    } frame_res_t;

    // Tracker state view for checks
    typedef struct packed {
        logic       open;
        logic [3:0] pos;
    } frame_stat_t;

    typedef struct packed {
        logic        frame_ok;
        logic        frame_kind;
        logic        data_ready;
        logic [15:0] co2_ppm;
        logic [14:0] temp_centi_c;
        logic [13:0] humidity_centi_pct;
    } result_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic phase_t pos_phase(input logic [3:0] pos);
        phase_t ph;
        case (pos)
            4'd0, 4'd3, 4'd6: ph = PH_HIGH;
            4'd1, 4'd4, 4'd7: ph = PH_LOW;
            default:          ph = PH_CRC;
        endcase
        return ph;
    endfunction

endpackage

@@ design/swfd_frame_ctl.sv @@
// Frame tracker: byte position, per-word CRC check and word capture.
module swfd_frame_ctl
    import swfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        beat_valid,
    input  logic [7:0]  beat_byte,
    input  logic        beat_cmd,
    input  logic        beat_start,
    output frame_res_t  res,
    output frame_stat_t stat
);

    logic        open_reg, open_next;
    logic [3:0]  pos_reg, pos_next;
    logic        kind_reg, kind_next;
    logic [7:0]  crc_reg, crc_next;
    logic        fail_reg, fail_next;
    logic [7:0]  hb_reg, hb_next;
    logic [15:0] w0_reg, w0_next;
    logic [15:0] w1_reg, w1_next;
    logic [15:0] w2_reg, w2_next;

    logic        open_eff;
    logic [3:0]  pos_eff;
    logic        kind_eff;
    logic [7:0]  crc_eff;
    logic        fail_eff;
    logic        is_last;
    logic [15:0] word;
    phase_t      phase;

    always_comb begin
        open_eff = beat_start | open_reg;
        pos_eff  = beat_start ? 4'd0 : pos_reg;
        kind_eff = beat_start ? beat_cmd : kind_reg;
        crc_eff  = beat_start ? CRC_INIT : crc_reg;
        fail_eff = beat_start ? 1'b0 : fail_reg;
        phase    = pos_phase(pos_eff);
        word     = {hb_reg, beat_byte};
        is_last  = pos_eff == ((kind_eff == KIND_MEAS) ? LAST_POS_MEAS : LAST_POS_STATUS);
    end

    always_comb begin
        open_next = open_reg;
        pos_next  = pos_reg;
        kind_next = kind_reg;
        crc_next  = crc_reg;
        fail_next = fail_reg;
        hb_next   = hb_reg;
        w0_next   = w0_reg;
        w1_next   = w1_reg;
        w2_next   = w2_reg;
        if (beat_valid && open_eff) begin
            kind_next = kind_eff;
            crc_next  = crc_eff;
            fail_next = fail_eff;
            case (phase)
                PH_HIGH: begin
                    hb_next  = beat_byte;
                    crc_next = crc8_step(CRC_INIT, beat_byte);
                end
                PH_LOW: begin
                    crc_next = crc8_step(crc_eff, beat_byte);
                    if (pos_eff < 4'd3) begin
                        w0_next = word;
                    end else if (pos_eff < 4'd6) begin
                        w1_next = word;
                    end else begin
                        w2_next = word;
                    end
                end
                default: begin
                    fail_next = fail_eff | (crc_eff != beat_byte);
                end
            endcase
            if (is_last) begin
                open_next = 1'b0;
                pos_next  = 4'd0;
            end else begin
                open_next = 1'b1;
                pos_next  = pos_eff + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
            pos_reg  <= 4'd0;
            kind_reg <= KIND_STATUS;
            crc_reg  <= CRC_INIT;
            fail_reg <= 1'b0;
        end else begin
            open_reg <= open_next;
            pos_reg  <= pos_next;
            kind_reg <= kind_next;
            crc_reg  <= crc_next;
            fail_reg <= fail_next;
        end
    end

    always_ff @(posedge aclk) begin
        hb_reg <= hb_next;
        w0_reg <= w0_next;
        w1_reg <= w1_next;
        w2_reg <= w2_next;
    end

    // Last byte is always a CRC byte, so all words are already registered
    always_comb begin
        res.emit = beat_valid && open_eff && is_last;
        res.ok   = ~fail_next;
        res.kind = kind_eff;
        res.w0   = w0_reg;
        res.w1   = w1_reg;
        res.w2   = w2_reg;
        stat.open = open_reg;
        stat.pos  = pos_reg;
    end

endmodule

@@ design/swfd_scale.sv @@
// Result formatting: data-ready flag and fixed-point temperature/humidity scaling.
module swfd_scale
    import swfd_pkg::*;
(
    input  frame_res_t fr,
    output result_t    res
);

    logic [30:0] t_prod;
    logic [29:0] h_prod;
    logic [14:0] t_val;
    logic        meas;

    always_comb begin
        meas   = fr.kind == KIND_MEAS;
        t_prod = 31'(fr.w1) * 31'(TEMP_SCALE);
        h_prod = 30'(fr.w2) * 30'(HUM_SCALE);
        t_val  = t_prod[30:16];

        res.frame_ok           = fr.ok;
        res.frame_kind         = fr.kind;
        res.data_ready         = meas ? 1'b0 : |(fr.w0[10:0] & READY_MASK);
        res.co2_ppm            = meas ? fr.w0 : 16'd0;
        res.temp_centi_c       = meas ? (t_val - TEMP_OFFSET) : 15'd0;
        res.humidity_centi_pct = meas ? h_prod[29:16] : 14'd0;
    end

endmodule

@@ design/sensor_word_frame_decoder_core.sv @@
// Path from input beat to result beat: input register, then result register.
// Throughput: one byte per cycle while m_tready is high; one result per completed frame.
// Timing path: CRC-8 step (eight XOR levels) or one 16x15 constant multiply per cycle.
// An input beat and a finished result may be held at once; s_tready drops only when both wait.
// Reset: synchronous active-low aresetn clears both valid stages and closes any open frame.
module sensor_word_frame_decoder_core
    import swfd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,  // [7:0] rx_byte
    input  logic [TUSER_IN_W-1:0]  s_tuser,  // [0] command, [1] frame_start
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,  // [0] frame_ok, [1] data_ready, [17:2] co2_ppm,
                                             // [32:18] temp_centi_c, [46:33] humidity_centi_pct
    output logic                   m_tuser   // [0] frame_kind
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_cmd_reg;
    logic        in_start_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;

    logic        advance;
    frame_res_t  fr;
    frame_stat_t fstat;
    result_t     res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata[7:0];
            in_cmd_reg   <= s_tuser[0];
            in_start_reg <= s_tuser[1];
        end
    end

    swfd_frame_ctl u_frame_ctl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (advance),
        .beat_byte  (in_byte_reg),
        .beat_cmd   (in_cmd_reg),
        .beat_start (in_start_reg),
        .res        (fr),
        .stat       (fstat)
    );

    swfd_scale u_scale (
        .fr  (fr),
        .res (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && fr.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && fr.emit) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.frame_kind;
    assign m_tdata  = {1'b0,
                       out_res_reg.humidity_centi_pct,
                       out_res_reg.temp_centi_c,
                       out_res_reg.co2_ppm,
                       out_res_reg.data_ready,
                       out_res_reg.frame_ok};

    a_closed_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !fstat.open |-> fstat.pos == 4'd0)
        else $error("byte position nonzero with no frame open");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fstat.pos <= LAST_POS_MEAS)
        else $error("byte position past end of measurement frame");

    a_status_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_STATUS) |-> m_tdata[46:2] == 45'd0)
        else $error("status result carries measurement fields");

    a_meas_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_MEAS) |->
            (m_tdata[46:33] <= 14'd9999 && !m_tdata[1] &&
             $signed(m_tdata[32:18]) >= -15'sd4500 && $signed(m_tdata[32:18]) <= 15'sd12999))
        else $error("measurement result out of range");

    a_emit_needs_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result raised without an input beat");

endmodule
